// ===== src/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure and temperature compensation block.
// Holds the request and response payload structs and the register map codes.
// Depends on nothing; every other file of the block imports it.
package bpc_pkg;

	localparam int RAW_W  = 24;
	localparam int COEF_W = 16;
	localparam int TEMP_W = 20;
	localparam int PRES_W = 17;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register map: each calibration word sits at byte address 4 * index.
	localparam logic [2:0] REG_SENS        = 3'd0;
	localparam logic [2:0] REG_OFFSET      = 3'd1;
	localparam logic [2:0] REG_SENS_TEMP   = 3'd2;
	localparam logic [2:0] REG_OFFSET_TEMP = 3'd3;
	localparam logic [2:0] REG_REF_TEMP    = 3'd4;
	localparam logic [2:0] REG_TEMP_SLOPE  = 3'd5;

	// Temperature reference point (20.00 C) and the distance from it to -15.00 C.
	localparam logic [TEMP_W-1:0] TEMP_REF   = 20'd2000;
	localparam logic [18:0]       COLD_SPAN  = 19'd3500;
	localparam logic [PRES_W-1:0] PRES_MAX   = 17'h1FFFF;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} bpc_req_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centi;
		logic [PRES_W-1:0]        pressure_centi;
		logic                     pressure_saturated;
	} bpc_rsp_t;

endpackage

// ===== src/baro_pressure_temp_compensation.sv =====
// Top level of the barometric pressure and temperature compensation block.
// Ten-stage pipeline with an APB-style register port for the six calibration words.
// Depends on bpc_pkg for the payload structs, widths and register codes.
//
//   channel   direction  handshake               payload
//   request   in         req_valid / req_ready   req_data (raw pressure, raw temperature)
//   response  out        rsp_valid / rsp_ready   rsp_data (temperature, pressure, clamp flag)
//   config    in         psel / penable / pready paddr, pwdata, prdata
//
// One request is taken every cycle while req_ready is high; each response follows its request
// through the ten register stages, among them the four parallel products of stage two,
// the second-order correction squares of stage four and the split 64-bit product of
// stages seven and eight. Reset clears the stage valid bits and the calibration words.
// A stage holds while it is full and the one after it cannot take its contents, so bubbles
// close up during a stall and the request side only stops when every stage holds a request.
module baro_pressure_temp_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  bpc_pkg::bpc_req_t               req_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output bpc_pkg::bpc_rsp_t               rsp_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bpc_pkg::ADDR_W-1:0]      paddr,
	input  logic [bpc_pkg::DATA_W-1:0]      pwdata,
	output logic [bpc_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);
	import bpc_pkg::*;

	// Calibration registers.
	logic [COEF_W-1:0] sens_q, offset_q, sens_temp_q, offset_temp_q, ref_temp_q, temp_slope_q;
	logic              cfg_wr;

	// Stage valid bits and per-stage advance enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	logic go_1, go_2, go_3, go_4, go_5, go_6, go_7, go_8, go_9, go_10;

	// Stage 1: temperature difference.
	logic signed [24:0] dt_s1;
	logic [RAW_W-1:0]   d1_s1;

	// Stage 2: first-order products.
	logic signed [41:0] mt_s2, mo_s2, ms_s2;
	logic signed [49:0] dd_s2;
	logic [RAW_W-1:0]   d1_s2;

	// Stage 3: first-order results and correction operands.
	logic signed [41:0]  mt_shr, mo_shr, ms_shr;
	logic signed [17:0]  a_c;
	logic signed [17:0]  a_s3;
	logic signed [18:0]  b_s3;
	logic                lt_a_s3, lt_b_s3;
	logic [TEMP_W-1:0]   temp1_s3;
	logic [35:0]         off1_s3, sens1_s3;
	logic [16:0]         t2_s3;
	logic [RAW_W-1:0]    d1_s3;

	// Stage 4: correction squares.
	logic signed [35:0]  aa_s4;
	logic signed [37:0]  bb_s4;
	logic                lt_a_s4, lt_b_s4;
	logic [TEMP_W-1:0]   temp1_s4;
	logic [35:0]         off1_s4, sens1_s4;
	logic [16:0]         t2_s4;
	logic [RAW_W-1:0]    d1_s4;

	// Stage 5: second-order terms and final temperature.
	logic [39:0]         aa40, bb40, off2a_c, sens2a_c, off2b_c, sens2b_c;
	logic [39:0]         off2_s5, sens2_s5;
	logic [TEMP_W-1:0]   temp_s5;
	logic [35:0]         off1_s5, sens1_s5;
	logic [RAW_W-1:0]    d1_s5;

	// Stage 6: compensated offset and sensitivity.
	logic [39:0]         off_s6, sens_s6;
	logic [TEMP_W-1:0]   temp_s6;
	logic [RAW_W-1:0]    d1_s6;

	// Stage 7: partial products of raw pressure and sensitivity.
	logic [43:0]         lo_s7;
	logic signed [44:0]  hi_s7;
	logic [39:0]         off_s7;
	logic [TEMP_W-1:0]   temp_s7;

	// Stage 8: full product.
	logic [64:0]         prod_sum;
	logic signed [63:0]  prod_s8;
	logic [39:0]         off_s8;
	logic [TEMP_W-1:0]   temp_s8;

	// Stage 9: scaled product less offset.
	logic signed [63:0]  prod_shr;
	logic signed [43:0]  q_s9;
	logic [TEMP_W-1:0]   temp_s9;

	// Stage 10: clamp and output register.
	logic signed [43:0]  p_full;
	logic                p_over;
	bpc_rsp_t            rsp_s10;

	// ------------------------------------------------------------------
	// Register port.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q        <= '0;
			offset_q      <= '0;
			sens_temp_q   <= '0;
			offset_temp_q <= '0;
			ref_temp_q    <= '0;
			temp_slope_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SENS:        sens_q        <= pwdata[COEF_W-1:0];
				REG_OFFSET:      offset_q      <= pwdata[COEF_W-1:0];
				REG_SENS_TEMP:   sens_temp_q   <= pwdata[COEF_W-1:0];
				REG_OFFSET_TEMP: offset_temp_q <= pwdata[COEF_W-1:0];
				REG_REF_TEMP:    ref_temp_q    <= pwdata[COEF_W-1:0];
				REG_TEMP_SLOPE:  temp_slope_q  <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_SENS:        prdata = {16'd0, sens_q};
			REG_OFFSET:      prdata = {16'd0, offset_q};
			REG_SENS_TEMP:   prdata = {16'd0, sens_temp_q};
			REG_OFFSET_TEMP: prdata = {16'd0, offset_temp_q};
			REG_REF_TEMP:    prdata = {16'd0, ref_temp_q};
			REG_TEMP_SLOPE:  prdata = {16'd0, temp_slope_q};
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage loads when it is empty or its
	// contents move on in the same cycle.
	// ------------------------------------------------------------------
	assign go_10 = !valid_s10 || rsp_ready;
	assign go_9  = !valid_s9  || go_10;
	assign go_8  = !valid_s8  || go_9;
	assign go_7  = !valid_s7  || go_8;
	assign go_6  = !valid_s6  || go_7;
	assign go_5  = !valid_s5  || go_6;
	assign go_4  = !valid_s4  || go_5;
	assign go_3  = !valid_s3  || go_4;
	assign go_2  = !valid_s2  || go_3;
	assign go_1  = !valid_s1  || go_2;

	assign req_ready = go_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			if (go_1)  valid_s1  <= req_valid;
			if (go_2)  valid_s2  <= valid_s1;
			if (go_3)  valid_s3  <= valid_s2;
			if (go_4)  valid_s4  <= valid_s3;
			if (go_5)  valid_s5  <= valid_s4;
			if (go_6)  valid_s6  <= valid_s5;
			if (go_7)  valid_s7  <= valid_s6;
			if (go_8)  valid_s8  <= valid_s7;
			if (go_9)  valid_s9  <= valid_s8;
			if (go_10) valid_s10 <= valid_s9;
		end
	end

	// ------------------------------------------------------------------
	// Combinational parts of the datapath.
	// ------------------------------------------------------------------
	always_comb begin
		mt_shr = mt_s2 >>> 23;
		mo_shr = mo_s2 >>> 7;
		ms_shr = ms_s2 >>> 8;
		a_c    = mt_shr[17:0];
	end

	// Both squares are non-negative, so the constant multiples are plain shift-adds.
	always_comb begin
		aa40     = {4'd0, aa_s4};
		bb40     = {2'd0, bb_s4};
		off2a_c  = lt_a_s4 ? (((aa40 << 2) + aa40) >> 1) : '0;
		sens2a_c = off2a_c >> 1;
		off2b_c  = lt_b_s4 ? ((bb40 << 3) - bb40) : '0;
		sens2b_c = lt_b_s4 ? (((bb40 << 3) + (bb40 << 1) + bb40) >> 1) : '0;
	end

	always_comb begin
		prod_sum = {hi_s7, 20'd0} + {21'd0, lo_s7};
		prod_shr = prod_s8 >>> 21;
		p_full   = q_s9 >>> 15;
		p_over   = !p_full[43] && (|p_full[43:17]);
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (go_1) begin
			dt_s1 <= $signed({1'b0, req_data.raw_temperature}) - $signed({1'b0, ref_temp_q, 8'd0});
			d1_s1 <= req_data.raw_pressure;
		end

		if (go_2) begin
			mt_s2 <= dt_s1 * $signed({1'b0, temp_slope_q});
			mo_s2 <= dt_s1 * $signed({1'b0, offset_temp_q});
			ms_s2 <= dt_s1 * $signed({1'b0, sens_temp_q});
			dd_s2 <= dt_s1 * dt_s1;
			d1_s2 <= d1_s1;
		end

		// The correction thresholds on temperature become sign tests on its distance
		// from 20.00 C and from -15.00 C.
		if (go_3) begin
			a_s3     <= a_c;
			b_s3     <= {a_c[17], a_c} + COLD_SPAN;
			lt_a_s3  <= a_c[17];
			lt_b_s3  <= ({a_c[17], a_c} + COLD_SPAN) >= 19'h40000;
			temp1_s3 <= {{2{a_c[17]}}, a_c} + TEMP_REF;
			off1_s3  <= {4'd0, offset_q, 16'd0} + mo_shr[35:0];
			sens1_s3 <= {5'd0, sens_q, 15'd0} + ms_shr[35:0];
			t2_s3    <= dd_s2[47:31];
			d1_s3    <= d1_s2;
		end

		if (go_4) begin
			aa_s4    <= a_s3 * a_s3;
			bb_s4    <= b_s3 * b_s3;
			lt_a_s4  <= lt_a_s3;
			lt_b_s4  <= lt_b_s3;
			temp1_s4 <= temp1_s3;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			t2_s4    <= t2_s3;
			d1_s4    <= d1_s3;
		end

		if (go_5) begin
			off2_s5  <= off2a_c + off2b_c;
			sens2_s5 <= sens2a_c + sens2b_c;
			temp_s5  <= temp1_s4 - (lt_a_s4 ? {3'd0, t2_s4} : {TEMP_W{1'b0}});
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			d1_s5    <= d1_s4;
		end

		if (go_6) begin
			off_s6  <= {{4{off1_s5[35]}}, off1_s5} - off2_s5;
			sens_s6 <= {{4{sens1_s5[35]}}, sens1_s5} - sens2_s5;
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
		end

		// The 24 by 40 bit product is split at bit 20 of the sensitivity.
		if (go_7) begin
			lo_s7   <= d1_s6 * sens_s6[19:0];
			hi_s7   <= $signed({1'b0, d1_s6}) * $signed(sens_s6[39:20]);
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end

		if (go_8) begin
			prod_s8 <= prod_sum[63:0];
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end

		if (go_9) begin
			q_s9    <= {prod_shr[42], prod_shr[42:0]} - {{4{off_s8[39]}}, off_s8};
			temp_s9 <= temp_s8;
		end

		if (go_10) begin
			rsp_s10.temp_centi <= temp_s9;
			if (p_full[43]) begin
				rsp_s10.pressure_centi     <= '0;
				rsp_s10.pressure_saturated <= 1'b1;
			end else if (p_over) begin
				rsp_s10.pressure_centi     <= PRES_MAX;
				rsp_s10.pressure_saturated <= 1'b1;
			end else begin
				rsp_s10.pressure_centi     <= p_full[PRES_W-1:0];
				rsp_s10.pressure_saturated <= 1'b0;
			end
		end
	end

	assign rsp_valid = valid_s10;
	assign rsp_data  = rsp_s10;

`ifndef SYNTHESIS
	// The request side may only stall when every stage is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 &&
			valid_s6 && valid_s7 && valid_s8 && valid_s9 && valid_s10))
		else $error("request side stalled with an empty stage");

	// A request leaving stage nine always lands in the output stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s9 && go_10) |=> valid_s10)
		else $error("request lost between stage nine and the output");

	// The -15 C correction only ever comes on top of the 20 C correction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && lt_b_s3) |-> lt_a_s3)
		else $error("cold correction selected without the low-temperature correction");

	// A clamped pressure sits at one of the two ends of its range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.pressure_saturated) |->
			(rsp_data.pressure_centi == '0 || rsp_data.pressure_centi == PRES_MAX))
		else $error("saturated pressure not at a range limit");
`endif

endmodule
